// ===== hdl/uart_trb_pkg.sv =====
// shared types, sizes and helpers for the uart transmit and receive ring buffers
`timescale 1ns / 1ps

package uart_trb_pkg;

	localparam int TX_DEPTH = 64;
	localparam int RX_DEPTH = 64;

	// pointers run modulo twice the depth so that full differs from empty
	localparam int TX_PW = $clog2(2 * TX_DEPTH);
	localparam int RX_PW = $clog2(2 * RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = $clog2(RX_DEPTH);

	localparam int LEVEL_W = 7;
	localparam int COUNT_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_EVENT = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + COUNT_W'(1);
	endfunction

endpackage

// ===== hdl/uart_trb_ctrl.sv =====
// request sequencer: capture, execute and result strobe
`timescale 1ns / 1ps

module uart_trb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	output uart_trb_pkg::ctrl_cmd_t cmd
);

	uart_trb_pkg::state_t state_q, state_n;
	logic                 load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uart_trb_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		busy    = 1'b0;
		done    = 1'b0;
		load    = 1'b0;
		state_n = state_q;
		unique case (state_q)
			uart_trb_pkg::ST_IDLE: begin
				load = start;
				if (start) begin
					state_n = uart_trb_pkg::ST_EXEC;
				end
			end
			uart_trb_pkg::ST_EXEC: begin
				busy    = 1'b1;
				state_n = uart_trb_pkg::ST_DONE;
			end
			uart_trb_pkg::ST_DONE: begin
				// result shows this cycle while the next request may enter
				done = 1'b1;
				load = start;
				state_n = start ? uart_trb_pkg::ST_EXEC : uart_trb_pkg::ST_IDLE;
			end
			default: begin
				state_n = uart_trb_pkg::ST_IDLE;
			end
		endcase
		cmd.load = load;
		cmd.exec = (state_q == uart_trb_pkg::ST_EXEC);
	end

endmodule

// ===== hdl/uart_trb_dp.sv =====
// ring memories, pointers, counters and result registers
`timescale 1ns / 1ps

module uart_trb_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  uart_trb_pkg::ctrl_cmd_t             cmd,
	input  logic [1:0]                          op,
	input  logic [7:0]                          tx_byte,
	input  logic                                line_txe,
	input  logic                                line_rxne,
	input  logic [7:0]                          rx_byte,
	input  logic [3:0]                          err_flags,
	output logic                                accepted,
	output logic [7:0]                          rx_data,
	output logic                                line_tx_valid,
	output logic [7:0]                          line_tx_byte,
	output logic                                tx_irq_enabled,
	output logic [uart_trb_pkg::LEVEL_W-1:0]    tx_level,
	output logic [uart_trb_pkg::LEVEL_W-1:0]    rx_level,
	output logic [uart_trb_pkg::COUNT_W-1:0]    sent_count,
	output logic [uart_trb_pkg::COUNT_W-1:0]    received_count,
	output logic [uart_trb_pkg::COUNT_W-1:0]    error_count
);

	// captured request
	uart_trb_pkg::op_t op_q;
	logic [7:0]        tx_byte_q;
	logic              txe_q;
	logic              rxne_q;
	logic [7:0]        rx_byte_q;
	logic [3:0]        err_q;

	// memories and their registered read data
	logic [7:0] tx_mem [uart_trb_pkg::TX_DEPTH];
	logic [7:0] rx_mem [uart_trb_pkg::RX_DEPTH];
	logic [7:0] tx_rdata_q;
	logic [7:0] rx_rdata_q;

	logic [uart_trb_pkg::TX_PW-1:0] tx_wr_q, tx_rd_q, tx_wr_n, tx_rd_n;
	logic [uart_trb_pkg::RX_PW-1:0] rx_wr_q, rx_rd_q, rx_wr_n, rx_rd_n;
	logic                           tx_idle_q, tx_idle_n;
	logic [uart_trb_pkg::COUNT_W-1:0] sent_q, recv_q, err_cnt_q;
	logic [uart_trb_pkg::COUNT_W-1:0] sent_n, recv_n, err_cnt_n;

	logic [uart_trb_pkg::TX_AW-1:0] tx_wr_slot, tx_rd_slot;
	logic [uart_trb_pkg::RX_AW-1:0] rx_wr_slot, rx_rd_slot;
	logic [uart_trb_pkg::TX_PW-1:0] tx_wr_inc, tx_rd_inc, tx_lvl, tx_lvl_n;
	logic [uart_trb_pkg::RX_PW-1:0] rx_wr_inc, rx_rd_inc, rx_lvl, rx_lvl_n;
	logic [uart_trb_pkg::TX_PW:0]   tx_wrap, tx_wrap_n;
	logic [uart_trb_pkg::RX_PW:0]   rx_wrap, rx_wrap_n;

	logic       tx_we, rx_we;
	logic       acc_n, txv_n;
	logic [7:0] rxd_n, txb_n;

	// result registers
	logic                             accepted_q, line_tx_valid_q;
	logic [7:0]                       rx_data_q, line_tx_byte_q;
	logic [uart_trb_pkg::LEVEL_W-1:0] tx_level_q, rx_level_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= uart_trb_pkg::op_t'(op);
			tx_byte_q <= tx_byte;
			txe_q     <= line_txe;
			rxne_q    <= line_rxne;
			rx_byte_q <= rx_byte;
			err_q     <= err_flags;
		end
	end

	// slot of a pointer: fold the upper half back onto the store
	always_comb begin
		tx_wr_slot = (tx_wr_q >= uart_trb_pkg::TX_PW'(uart_trb_pkg::TX_DEPTH))
			? uart_trb_pkg::TX_AW'(tx_wr_q - uart_trb_pkg::TX_PW'(uart_trb_pkg::TX_DEPTH))
			: uart_trb_pkg::TX_AW'(tx_wr_q);
		tx_rd_slot = (tx_rd_q >= uart_trb_pkg::TX_PW'(uart_trb_pkg::TX_DEPTH))
			? uart_trb_pkg::TX_AW'(tx_rd_q - uart_trb_pkg::TX_PW'(uart_trb_pkg::TX_DEPTH))
			: uart_trb_pkg::TX_AW'(tx_rd_q);
		rx_wr_slot = (rx_wr_q >= uart_trb_pkg::RX_PW'(uart_trb_pkg::RX_DEPTH))
			? uart_trb_pkg::RX_AW'(rx_wr_q - uart_trb_pkg::RX_PW'(uart_trb_pkg::RX_DEPTH))
			: uart_trb_pkg::RX_AW'(rx_wr_q);
		rx_rd_slot = (rx_rd_q >= uart_trb_pkg::RX_PW'(uart_trb_pkg::RX_DEPTH))
			? uart_trb_pkg::RX_AW'(rx_rd_q - uart_trb_pkg::RX_PW'(uart_trb_pkg::RX_DEPTH))
			: uart_trb_pkg::RX_AW'(rx_rd_q);

		tx_wr_inc = (tx_wr_q == uart_trb_pkg::TX_PW'(2 * uart_trb_pkg::TX_DEPTH - 1))
			? '0 : tx_wr_q + uart_trb_pkg::TX_PW'(1);
		tx_rd_inc = (tx_rd_q == uart_trb_pkg::TX_PW'(2 * uart_trb_pkg::TX_DEPTH - 1))
			? '0 : tx_rd_q + uart_trb_pkg::TX_PW'(1);
		rx_wr_inc = (rx_wr_q == uart_trb_pkg::RX_PW'(2 * uart_trb_pkg::RX_DEPTH - 1))
			? '0 : rx_wr_q + uart_trb_pkg::RX_PW'(1);
		rx_rd_inc = (rx_rd_q == uart_trb_pkg::RX_PW'(2 * uart_trb_pkg::RX_DEPTH - 1))
			? '0 : rx_rd_q + uart_trb_pkg::RX_PW'(1);

		tx_wrap = {1'b0, tx_wr_q} + (uart_trb_pkg::TX_PW + 1)'(2 * uart_trb_pkg::TX_DEPTH)
			- {1'b0, tx_rd_q};
		rx_wrap = {1'b0, rx_wr_q} + (uart_trb_pkg::RX_PW + 1)'(2 * uart_trb_pkg::RX_DEPTH)
			- {1'b0, rx_rd_q};
		tx_lvl = (tx_wr_q >= tx_rd_q) ? tx_wr_q - tx_rd_q
			: uart_trb_pkg::TX_PW'(tx_wrap);
		rx_lvl = (rx_wr_q >= rx_rd_q) ? rx_wr_q - rx_rd_q
			: uart_trb_pkg::RX_PW'(rx_wrap);
	end

	always_comb begin
		tx_wr_n   = tx_wr_q;
		tx_rd_n   = tx_rd_q;
		rx_wr_n   = rx_wr_q;
		rx_rd_n   = rx_rd_q;
		tx_idle_n = tx_idle_q;
		sent_n    = sent_q;
		recv_n    = recv_q;
		err_cnt_n = err_cnt_q;
		tx_we     = 1'b0;
		rx_we     = 1'b0;
		acc_n     = 1'b0;
		txv_n     = 1'b0;
		rxd_n     = '0;
		txb_n     = '0;
		case (op_q)
			uart_trb_pkg::OP_PUSH: begin
				if (tx_lvl != uart_trb_pkg::TX_PW'(uart_trb_pkg::TX_DEPTH)) begin
					tx_we     = 1'b1;
					tx_wr_n   = tx_wr_inc;
					tx_idle_n = 1'b0;
					acc_n     = 1'b1;
				end
			end
			uart_trb_pkg::OP_POP: begin
				if (rx_wr_q != rx_rd_q) begin
					rxd_n   = rx_rdata_q;
					rx_rd_n = rx_rd_inc;
					acc_n   = 1'b1;
				end
			end
			uart_trb_pkg::OP_EVENT: begin
				acc_n = 1'b1;
				// transmit side first, then receive
				if (txe_q) begin
					if (tx_wr_q != tx_rd_q) begin
						txv_n     = 1'b1;
						txb_n     = tx_rdata_q;
						tx_rd_n   = tx_rd_inc;
						tx_idle_n = 1'b0;
						sent_n    = uart_trb_pkg::sat_inc(sent_q);
					end else begin
						tx_idle_n = 1'b1;
					end
				end
				if (rxne_q && (rx_lvl != uart_trb_pkg::RX_PW'(uart_trb_pkg::RX_DEPTH))) begin
					rx_we   = 1'b1;
					rx_wr_n = rx_wr_inc;
					recv_n  = uart_trb_pkg::sat_inc(recv_q);
				end
				if (err_q != 4'd0) begin
					err_cnt_n = uart_trb_pkg::sat_inc(err_cnt_q);
				end
			end
			uart_trb_pkg::OP_FLUSH: begin
				acc_n     = 1'b1;
				tx_wr_n   = '0;
				tx_rd_n   = '0;
				rx_wr_n   = '0;
				rx_rd_n   = '0;
				tx_idle_n = 1'b1;
			end
			default: begin
			end
		endcase

		tx_wrap_n = {1'b0, tx_wr_n} + (uart_trb_pkg::TX_PW + 1)'(2 * uart_trb_pkg::TX_DEPTH)
			- {1'b0, tx_rd_n};
		rx_wrap_n = {1'b0, rx_wr_n} + (uart_trb_pkg::RX_PW + 1)'(2 * uart_trb_pkg::RX_DEPTH)
			- {1'b0, rx_rd_n};
		tx_lvl_n = (tx_wr_n >= tx_rd_n) ? tx_wr_n - tx_rd_n
			: uart_trb_pkg::TX_PW'(tx_wrap_n);
		rx_lvl_n = (rx_wr_n >= rx_rd_n) ? rx_wr_n - rx_rd_n
			: uart_trb_pkg::RX_PW'(rx_wrap_n);
	end

	// reads are taken with the request, writes land in the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_rdata_q <= tx_mem[tx_rd_slot];
			rx_rdata_q <= rx_mem[rx_rd_slot];
		end
		if (cmd.exec && tx_we) begin
			tx_mem[tx_wr_slot] <= tx_byte_q;
		end
		if (cmd.exec && rx_we) begin
			rx_mem[rx_wr_slot] <= rx_byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_q   <= '0;
			tx_rd_q   <= '0;
			rx_wr_q   <= '0;
			rx_rd_q   <= '0;
			tx_idle_q <= 1'b1;
			sent_q    <= '0;
			recv_q    <= '0;
			err_cnt_q <= '0;
		end else if (cmd.exec) begin
			tx_wr_q   <= tx_wr_n;
			tx_rd_q   <= tx_rd_n;
			rx_wr_q   <= rx_wr_n;
			rx_rd_q   <= rx_rd_n;
			tx_idle_q <= tx_idle_n;
			sent_q    <= sent_n;
			recv_q    <= recv_n;
			err_cnt_q <= err_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			accepted_q      <= acc_n;
			rx_data_q       <= rxd_n;
			line_tx_valid_q <= txv_n;
			line_tx_byte_q  <= txb_n;
			tx_level_q      <= uart_trb_pkg::LEVEL_W'(tx_lvl_n);
			rx_level_q      <= uart_trb_pkg::LEVEL_W'(rx_lvl_n);
		end
	end

	assign accepted       = accepted_q;
	assign rx_data        = rx_data_q;
	assign line_tx_valid  = line_tx_valid_q;
	assign line_tx_byte   = line_tx_byte_q;
	assign tx_irq_enabled = ~tx_idle_q;
	assign tx_level       = tx_level_q;
	assign rx_level       = rx_level_q;
	assign sent_count     = sent_q;
	assign received_count = recv_q;
	assign error_count    = err_cnt_q;

endmodule

// ===== hdl/uart_tx_rx_ring_buffers_top.sv =====
// top level of the uart transmit and receive ring buffers
//
//  channel   handshake          payload
//  request   start / busy       op tx_byte line_txe line_rxne rx_byte err_flags
//  result    done (one cycle)   accepted rx_data line_tx_valid line_tx_byte
//                               tx_irq_enabled tx_level rx_level sent_count
//                               received_count error_count
//
// per request: memories read at the accepting edge, state and
// result registers updated in the execute cycle, done shown in the cycle after
// a new request may be accepted in the done cycle, but not while one is executing
// busy is high only in the execute cycle
// arst_n clears pointers, counters and the sequencer; ring contents are not cleared
// done lasts one cycle and the result ports are not held for the receiver
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [7:0]                       tx_byte,
	input  logic                             line_txe,
	input  logic                             line_rxne,
	input  logic [7:0]                       rx_byte,
	input  logic [3:0]                       err_flags,
	output logic                             done,
	output logic                             accepted,
	output logic [7:0]                       rx_data,
	output logic                             line_tx_valid,
	output logic [7:0]                       line_tx_byte,
	output logic                             tx_irq_enabled,
	output logic [uart_trb_pkg::LEVEL_W-1:0] tx_level,
	output logic [uart_trb_pkg::LEVEL_W-1:0] rx_level,
	output logic [uart_trb_pkg::COUNT_W-1:0] sent_count,
	output logic [uart_trb_pkg::COUNT_W-1:0] received_count,
	output logic [uart_trb_pkg::COUNT_W-1:0] error_count
);

	uart_trb_pkg::ctrl_cmd_t cmd;

	uart_trb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	uart_trb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (op),
		.tx_byte        (tx_byte),
		.line_txe       (line_txe),
		.line_rxne      (line_rxne),
		.rx_byte        (rx_byte),
		.err_flags      (err_flags),
		.accepted       (accepted),
		.rx_data        (rx_data),
		.line_tx_valid  (line_tx_valid),
		.line_tx_byte   (line_tx_byte),
		.tx_irq_enabled (tx_irq_enabled),
		.tx_level       (tx_level),
		.rx_level       (rx_level),
		.sent_count     (sent_count),
		.received_count (received_count),
		.error_count    (error_count)
	);

endmodule

// ===== bench/uart_tx_rx_ring_buffers_top_tb.sv =====
// self-checking testbench for the uart transmit and receive ring buffers top level
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_top_tb;

	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// shapes of the random part
	localparam int MODE_FILL_TX = 0;
	localparam int MODE_FILL_RX = 1;
	localparam int MODE_DRAIN = 2;
	localparam int MODE_MIX = 3;

	typedef struct packed {
		uart_trb_pkg::op_t op;
		logic [7:0]        tx_byte;
		logic              txe;
		logic              rxne;
		logic [7:0]        rx_byte;
		logic [3:0]        err;
	} uart_req_t;

	typedef struct packed {
		logic                             accepted;
		logic [7:0]                       rx_data;
		logic                             tx_valid;
		logic [7:0]                       tx_b;
		logic                             irq;
		logic [uart_trb_pkg::LEVEL_W-1:0] tx_lvl;
		logic [uart_trb_pkg::LEVEL_W-1:0] rx_lvl;
		logic [uart_trb_pkg::COUNT_W-1:0] sent;
		logic [uart_trb_pkg::COUNT_W-1:0] rcvd;
		logic [uart_trb_pkg::COUNT_W-1:0] errs;
	} uart_res_t;

	typedef struct packed {
		uart_req_t req;
		logic      typed;
		uart_res_t res;
	} dir_row_t;

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [1:0]                       op = 2'd0;
	logic [7:0]                       tx_byte = 8'h00;
	logic                             line_txe = 1'b0;
	logic                             line_rxne = 1'b0;
	logic [7:0]                       rx_byte = 8'h00;
	logic [3:0]                       err_flags = 4'h0;
	logic                             done;
	logic                             accepted;
	logic [7:0]                       rx_data;
	logic                             line_tx_valid;
	logic [7:0]                       line_tx_byte;
	logic                             tx_irq_enabled;
	logic [uart_trb_pkg::LEVEL_W-1:0] tx_level;
	logic [uart_trb_pkg::LEVEL_W-1:0] rx_level;
	logic [uart_trb_pkg::COUNT_W-1:0] sent_count;
	logic [uart_trb_pkg::COUNT_W-1:0] received_count;
	logic [uart_trb_pkg::COUNT_W-1:0] error_count;

	uart_tx_rx_ring_buffers_top dut (.*);

	// predictor state
	logic [7:0]                       tx_mem [uart_trb_pkg::TX_DEPTH];
	logic [7:0]                       rx_mem [uart_trb_pkg::RX_DEPTH];
	logic [uart_trb_pkg::TX_PW-1:0]   tx_head = '0;
	logic [uart_trb_pkg::TX_PW-1:0]   tx_tail = '0;
	logic [uart_trb_pkg::RX_PW-1:0]   rx_head = '0;
	logic [uart_trb_pkg::RX_PW-1:0]   rx_tail = '0;
	logic                             line_idle = 1'b1;
	logic [uart_trb_pkg::COUNT_W-1:0] n_sent = '0;
	logic [uart_trb_pkg::COUNT_W-1:0] n_rcvd = '0;
	logic [uart_trb_pkg::COUNT_W-1:0] n_errs = '0;

	uart_res_t pending_results [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;

	dir_row_t directed_table [0:20] = '{
		// pop right after reset
		'{'{uart_trb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0}},
		// transmitter empty with nothing queued
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0}},
		// all error flags, no data
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b0, 1'b0, 8'h00, 4'hF}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd0, 32'd0, 32'd1}},
		// push while idle, line fields ignored
		'{'{uart_trb_pkg::OP_PUSH, 8'hFF, 1'b1, 1'b1, 8'hAA, 4'hF}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 7'd1, 7'd0, 32'd0, 32'd0, 32'd1}},
		'{'{uart_trb_pkg::OP_PUSH, 8'h00, 1'b0, 1'b0, 8'h55, 4'h0}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 7'd2, 7'd0, 32'd0, 32'd0, 32'd1}},
		// transmit and receive in one event
		'{'{uart_trb_pkg::OP_EVENT, 8'h33, 1'b1, 1'b1, 8'hFF, 4'h1}, 1'b1,
		  '{1'b1, 8'h00, 1'b1, 8'hFF, 1'b1, 7'd1, 7'd1, 32'd1, 32'd1, 32'd2}},
		'{'{uart_trb_pkg::OP_EVENT, 8'hCC, 1'b1, 1'b1, 8'h00, 4'h8}, 1'b1,
		  '{1'b1, 8'h00, 1'b1, 8'h00, 1'b1, 7'd0, 7'd2, 32'd2, 32'd2, 32'd3}},
		// ring drained, transmitter goes idle
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd2, 32'd2, 32'd2, 32'd3}},
		'{'{uart_trb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 7'd0, 7'd1, 32'd2, 32'd2, 32'd3}},
		'{'{uart_trb_pkg::OP_POP, 8'hFF, 1'b1, 1'b1, 8'hFF, 4'hF}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd2, 32'd2, 32'd3}},
		// pop from empty ring
		'{'{uart_trb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd2, 32'd2, 32'd3}},
		'{'{uart_trb_pkg::OP_PUSH, 8'h5A, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
		'{'{uart_trb_pkg::OP_PUSH, 8'hA5, 1'b1, 1'b0, 8'h00, 4'h2}, 1'b0, '0},
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b1, 8'h3C, 4'h2}, 1'b0, '0},
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b0, 1'b1, 8'hC3, 4'h0}, 1'b0, '0},
		// flush keeps the counters
		'{'{uart_trb_pkg::OP_FLUSH, 8'hFF, 1'b1, 1'b1, 8'hFF, 4'hF}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd3, 32'd4, 32'd4}},
		'{'{uart_trb_pkg::OP_POP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd3, 32'd4, 32'd4}},
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 4'h0}, 1'b1,
		  '{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 7'd0, 7'd0, 32'd3, 32'd4, 32'd4}},
		'{'{uart_trb_pkg::OP_PUSH, 8'h81, 1'b0, 1'b0, 8'h00, 4'h0}, 1'b0, '0},
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b1, 8'h7E, 4'h0}, 1'b0, '0},
		'{'{uart_trb_pkg::OP_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 4'h4}, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [uart_trb_pkg::COUNT_W-1:0] bump(
		logic [uart_trb_pkg::COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// advance the rings by one request and return what the block should answer
	function automatic uart_res_t ring_step(uart_req_t r);
		uart_res_t res;
		logic [uart_trb_pkg::TX_PW-1:0] tx_fill;
		logic [uart_trb_pkg::RX_PW-1:0] rx_fill;
		res = '0;
		tx_fill = tx_head - tx_tail;
		rx_fill = rx_head - rx_tail;
		case (r.op)
			uart_trb_pkg::OP_PUSH: begin
				if (tx_fill < uart_trb_pkg::TX_DEPTH) begin
					tx_mem[tx_head[uart_trb_pkg::TX_AW-1:0]] = r.tx_byte;
					tx_head = tx_head + 1'b1;
					line_idle = 1'b0;
					res.accepted = 1'b1;
				end
			end
			uart_trb_pkg::OP_POP: begin
				if (rx_fill != 0) begin
					res.rx_data = rx_mem[rx_tail[uart_trb_pkg::RX_AW-1:0]];
					rx_tail = rx_tail + 1'b1;
					res.accepted = 1'b1;
				end
			end
			uart_trb_pkg::OP_EVENT: begin
				res.accepted = 1'b1;
				// transmit side first, then receive
				if (r.txe) begin
					if (tx_fill != 0) begin
						res.tx_valid = 1'b1;
						res.tx_b = tx_mem[tx_tail[uart_trb_pkg::TX_AW-1:0]];
						tx_tail = tx_tail + 1'b1;
						line_idle = 1'b0;
						n_sent = bump(n_sent);
					end else begin
						line_idle = 1'b1;
					end
				end
				if (r.rxne && rx_fill < uart_trb_pkg::RX_DEPTH) begin
					rx_mem[rx_head[uart_trb_pkg::RX_AW-1:0]] = r.rx_byte;
					rx_head = rx_head + 1'b1;
					n_rcvd = bump(n_rcvd);
				end
				if (r.err != 4'h0)
					n_errs = bump(n_errs);
			end
			default: begin
				res.accepted = 1'b1;
				tx_head = '0;
				tx_tail = '0;
				rx_head = '0;
				rx_tail = '0;
				line_idle = 1'b1;
			end
		endcase
		res.irq = ~line_idle;
		res.tx_lvl = uart_trb_pkg::LEVEL_W'(tx_head - tx_tail);
		res.rx_lvl = uart_trb_pkg::LEVEL_W'(rx_head - rx_tail);
		res.sent = n_sent;
		res.rcvd = n_rcvd;
		res.errs = n_errs;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// sender bursts: a random gap now and then, long runs with none
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 6)) begin
					@(negedge clk);
					start <= 1'b0;
				end
		end
		burst_left--;
	endtask

	task automatic send_request(uart_req_t r, logic typed, uart_res_t typed_res);
		uart_res_t predicted;
		pace_sender();
		@(negedge clk);
		start <= 1'b1;
		op <= r.op;
		tx_byte <= r.tx_byte;
		line_txe <= r.txe;
		line_rxne <= r.rxne;
		rx_byte <= r.rx_byte;
		err_flags <= r.err;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = ring_step(r);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		uart_res_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("done with no request pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (accepted !== want.accepted)
					report_mismatch("accepted", accepted, want.accepted);
				if (rx_data !== want.rx_data)
					report_mismatch("rx_data", rx_data, want.rx_data);
				if (line_tx_valid !== want.tx_valid)
					report_mismatch("line_tx_valid", line_tx_valid, want.tx_valid);
				if (line_tx_byte !== want.tx_b)
					report_mismatch("line_tx_byte", line_tx_byte, want.tx_b);
				if (tx_irq_enabled !== want.irq)
					report_mismatch("tx_irq_enabled", tx_irq_enabled, want.irq);
				if (tx_level !== want.tx_lvl)
					report_mismatch("tx_level", tx_level, want.tx_lvl);
				if (rx_level !== want.rx_lvl)
					report_mismatch("rx_level", rx_level, want.rx_lvl);
				if (sent_count !== want.sent)
					report_mismatch("sent_count", sent_count, want.sent);
				if (received_count !== want.rcvd)
					report_mismatch("received_count", received_count, want.rcvd);
				if (error_count !== want.errs)
					report_mismatch("error_count", error_count, want.errs);
			end
		end
	end

	initial begin
		uart_req_t req;
		int mode;
		int seg_left;
		int pick;
		int n;
		mode = MODE_MIX;
		seg_left = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_table[i])
			send_request(directed_table[i].req, directed_table[i].typed, directed_table[i].res);

		// segments that fill, drain or mix the rings so both reach full and empty
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				mode = $urandom_range(MODE_FILL_TX, MODE_MIX);
				seg_left = $urandom_range(30, 120);
			end
			seg_left--;
			req.tx_byte = 8'($urandom);
			req.txe = 1'($urandom);
			req.rxne = 1'($urandom);
			req.rx_byte = 8'($urandom);
			req.err = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
			pick = $urandom_range(0, 99);
			case (mode)
				MODE_FILL_TX: begin
					req.op = (pick < 85) ? uart_trb_pkg::OP_PUSH :
						(pick < 97) ? uart_trb_pkg::OP_EVENT : uart_trb_pkg::OP_POP;
					req.txe = 1'b0;
				end
				MODE_FILL_RX: begin
					req.op = (pick < 85) ? uart_trb_pkg::OP_EVENT :
						(pick < 95) ? uart_trb_pkg::OP_POP : uart_trb_pkg::OP_PUSH;
					req.txe = 1'b0;
					req.rxne = 1'b1;
				end
				MODE_DRAIN: begin
					req.op = (pick < 50) ? uart_trb_pkg::OP_EVENT :
						(pick < 95) ? uart_trb_pkg::OP_POP : uart_trb_pkg::OP_PUSH;
					req.txe = 1'b1;
					req.rxne = 1'b0;
				end
				default: begin
					req.op = (pick < 30) ? uart_trb_pkg::OP_PUSH :
						(pick < 55) ? uart_trb_pkg::OP_POP :
						(pick < 97) ? uart_trb_pkg::OP_EVENT : uart_trb_pkg::OP_FLUSH;
				end
			endcase
			send_request(req, 1'b0, '0);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
